>>> hw/rtl/slh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package slh_pkg;

  // Default sizing
  localparam int BIN_COUNT_DEF   = 1024;
  localparam int COUNT_WIDTH_DEF = 32;

  // Fixed field widths
  localparam int VAL_W     = 11;
  localparam int BOUND_W   = 10;
  localparam int REQ_W     = 2;
  localparam int STAT_W    = 2;
  localparam int OUT_CNT_W = 32;
  localparam int CFG_IDX_W = 1;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_COUNT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;
  localparam logic [REQ_W-1:0] REQ_NOP   = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_SAT   = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_POS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_NEG = 1'd1;

  localparam logic [BOUND_W-1:0] MAX_POS_RST = 10'd1023;
  localparam logic [BOUND_W-1:0] MAX_NEG_RST = 10'd0;

  typedef struct packed {
    logic             hit;  // inside configured bound (bin count checked elsewhere)
    logic             neg;  // negative bank
    logic [VAL_W-1:0] mag;  // magnitude
  } loc_t;

  function automatic loc_t locate(logic signed [VAL_W-1:0] v,
                                  logic [BOUND_W-1:0] max_pos,
                                  logic [BOUND_W-1:0] max_neg);
    loc_t r;
    r.neg = v[VAL_W-1];
    r.mag = v[VAL_W-1] ? VAL_W'(-v) : VAL_W'(v);
    r.hit = v[VAL_W-1] ? (r.mag <= {1'b0, max_neg}) : (r.mag <= {1'b0, max_pos});
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/signed_latency_histogram.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  in_req_type, in_sample_value, in_bin_index
// out      output     out_valid / out_stall out_bin_count, out_status
// cfg      input      cfg_we               cfg_index, cfg_wdata
//
// Count and read items: one item per cycle while out_stall is low; each item
// passes from stage one into the output register, which raises out_valid.
// The rate is set by the bank read-modify-write; the write of one item is
// forwarded to the next item that reads the same bin.
// Clear item: its result leaves at once, then a sweep zeroes both banks, one entry
// per cycle; no item is taken during the sweep.
// Reset (rst_n low, synchronous) starts the same sweep.
// out_stall holds the output register and, once stage one is full, stalls in.
module signed_latency_histogram #(
  parameter int BIN_COUNT   = slh_pkg::BIN_COUNT_DEF,
  parameter int COUNT_WIDTH = slh_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // configuration
  input  wire logic                                cfg_we,
  input  wire logic [slh_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [slh_pkg::BOUND_W-1:0]         cfg_wdata,
  // request items
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [slh_pkg::REQ_W-1:0]           in_req_type,
  input  wire logic signed [slh_pkg::VAL_W-1:0]    in_sample_value,
  input  wire logic signed [slh_pkg::VAL_W-1:0]    in_bin_index,
  // result items
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [slh_pkg::OUT_CNT_W-1:0]            out_bin_count,
  output logic [slh_pkg::STAT_W-1:0]               out_status
);

  localparam int AW = $clog2(BIN_COUNT);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  // ---------------------------------------------------------------- config
  logic [slh_pkg::BOUND_W-1:0] max_pos_r, max_neg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_pos_r <= slh_pkg::MAX_POS_RST;
      max_neg_r <= slh_pkg::MAX_NEG_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        slh_pkg::CFG_MAX_POS: max_pos_r <= cfg_wdata;
        slh_pkg::CFG_MAX_NEG: max_neg_r <= cfg_wdata;
      endcase
    end
  end

  // ---------------------------------------------------------------- decode
  logic                               in_acc;
  logic signed [slh_pkg::VAL_W-1:0]   in_val;
  slh_pkg::loc_t                      in_loc;
  logic [31:0]                        in_mag_ext;
  logic                               in_hit;
  logic [AW-1:0]                      in_addr;

  assign in_acc     = in_valid & ~in_stall;
  assign in_val     = (in_req_type == slh_pkg::REQ_READ) ? in_bin_index : in_sample_value;
  assign in_loc     = slh_pkg::locate(in_val, max_pos_r, max_neg_r);
  assign in_mag_ext = 32'(in_loc.mag);
  assign in_hit     = in_loc.hit & (in_mag_ext < 32'(BIN_COUNT));
  assign in_addr    = in_mag_ext[AW-1:0];

  // ---------------------------------------------------------------- stage one
  logic                        s1_valid_r;
  logic [slh_pkg::REQ_W-1:0]   s1_req_r;
  logic                        s1_hit_r;
  logic                        s1_neg_r;
  logic [AW-1:0]               s1_addr_r;

  logic                        out_valid_r;
  logic [slh_pkg::OUT_CNT_W-1:0] out_bin_count_r;
  logic [slh_pkg::STAT_W-1:0]  out_status_r;

  logic s1_adv;      // stage one moves into the output register
  logic clr_busy;
  logic clr_start;
  logic [AW-1:0] clr_idx;

  assign s1_adv    = s1_valid_r & (~out_valid_r | ~out_stall);
  assign clr_start = s1_adv & (s1_req_r == slh_pkg::REQ_CLEAR);
  // A clear item in stage one holds off the next item until the sweep is done.
  assign in_stall  = clr_busy |
                     (s1_valid_r & (~s1_adv | (s1_req_r == slh_pkg::REQ_CLEAR)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_r  <= in_req_type;
      s1_hit_r  <= in_hit;
      s1_neg_r  <= in_loc.neg;
      s1_addr_r <= in_addr;
    end
  end

  // ---------------------------------------------------------------- banks
  logic [COUNT_WIDTH-1:0] pos_rd, neg_rd;
  logic                   item_we;
  logic                   pos_we, neg_we;
  logic [AW-1:0]          wr_addr;
  logic [COUNT_WIDTH-1:0] wr_data;
  logic [COUNT_WIDTH-1:0] new_cnt;

  assign item_we = s1_adv & (s1_req_r == slh_pkg::REQ_COUNT) & s1_hit_r;
  assign pos_we  = clr_busy | (item_we & ~s1_neg_r);
  assign neg_we  = clr_busy | (item_we & s1_neg_r);
  assign wr_addr = clr_busy ? clr_idx : s1_addr_r;
  assign wr_data = clr_busy ? '0 : new_cnt;

  slh_bank #(.DEPTH(BIN_COUNT), .WIDTH(COUNT_WIDTH), .AW(AW)) u_pos_bank (
    .clk     (clk),
    .wr_en   (pos_we),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (in_acc),
    .rd_addr (in_addr),
    .rd_data (pos_rd)
  );

  slh_bank #(.DEPTH(BIN_COUNT), .WIDTH(COUNT_WIDTH), .AW(AW)) u_neg_bank (
    .clk     (clk),
    .wr_en   (neg_we),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (in_acc),
    .rd_addr (in_addr),
    .rd_data (neg_rd)
  );

  slh_clear #(.DEPTH(BIN_COUNT), .AW(AW)) u_clear (
    .clk   (clk),
    .rst_n (rst_n),
    .start (clr_start),
    .busy  (clr_busy),
    .idx   (clr_idx)
  );

  // ---------------------------------------------------------------- forwarding
  // Last item write. The bank read issued in the same cycle as that write sees
  // the old value, so a matching bin takes this copy instead; it always holds
  // the newest value of its bin until a sweep wipes it.
  logic                   fwd_valid_r;
  logic                   fwd_neg_r;
  logic [AW-1:0]          fwd_addr_r;
  logic [COUNT_WIDTH-1:0] fwd_data_r;
  logic                   fwd_hit;
  logic [COUNT_WIDTH-1:0] cur_cnt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
    end else if (clr_busy) begin
      fwd_valid_r <= 1'b0;
    end else if (item_we) begin
      fwd_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (item_we) begin
      fwd_neg_r  <= s1_neg_r;
      fwd_addr_r <= s1_addr_r;
      fwd_data_r <= new_cnt;
    end
  end

  assign fwd_hit = fwd_valid_r & (fwd_neg_r == s1_neg_r) & (fwd_addr_r == s1_addr_r);
  assign cur_cnt = fwd_hit ? fwd_data_r : (s1_neg_r ? neg_rd : pos_rd);

  // ---------------------------------------------------------------- result
  logic                          sat;
  logic [COUNT_WIDTH-1:0]        res_cnt;
  logic [slh_pkg::STAT_W-1:0]    res_stat;
  logic [63:0]                   res_wide;

  assign sat     = (cur_cnt == COUNT_MAX);
  // saturated bins are rewritten with their own value
  assign new_cnt = sat ? cur_cnt : cur_cnt + COUNT_WIDTH'(1);

  always_comb begin
    res_cnt  = '0;
    res_stat = slh_pkg::ST_OK;
    unique case (s1_req_r)
      slh_pkg::REQ_COUNT: begin
        if (!s1_hit_r) begin
          res_stat = slh_pkg::ST_RANGE;
        end else if (sat) begin
          res_cnt  = cur_cnt;
          res_stat = slh_pkg::ST_SAT;
        end else begin
          res_cnt  = new_cnt;
        end
      end
      slh_pkg::REQ_READ: begin
        if (!s1_hit_r) begin
          res_stat = slh_pkg::ST_RANGE;
        end else begin
          res_cnt  = cur_cnt;
        end
      end
      slh_pkg::REQ_CLEAR, slh_pkg::REQ_NOP: begin
        res_cnt  = '0;
        res_stat = slh_pkg::ST_OK;
      end
    endcase
  end

  assign res_wide = 64'(res_cnt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_bin_count_r <= res_wide[slh_pkg::OUT_CNT_W-1:0];
      out_status_r    <= res_stat;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_bin_count = out_bin_count_r;
  assign out_status    = out_status_r;

  // ---------------------------------------------------------------- checks
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !in_acc)
    else $error("item accepted during clear sweep");

  a_no_item_write_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !item_we)
    else $error("item write collides with clear sweep");

  a_clear_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    clr_start |=> clr_busy)
    else $error("clear item did not start sweep");

  a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == slh_pkg::ST_RANGE) |-> out_bin_count_r == '0)
    else $error("out-of-range result carries a count");

  a_fwd_dropped_by_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |=> !fwd_valid_r)
    else $error("forward copy survived a clear sweep");

endmodule
`default_nettype wire

>>> hw/rtl/slh_bank.sv
`timescale 1ns / 1ps
`default_nettype none
// Single-port-write, single-port-read synchronous RAM, registered read,
// read returns old data on a same-address write.
module slh_bank #(
  parameter int DEPTH = slh_pkg::BIN_COUNT_DEF,
  parameter int WIDTH = slh_pkg::COUNT_WIDTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

>>> hw/rtl/slh_clear.sv
`timescale 1ns / 1ps
`default_nettype none
// Clear sweep: one entry per cycle through both banks, runs from reset and again on start.
module slh_clear #(
  parameter int DEPTH = slh_pkg::BIN_COUNT_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  output logic [AW-1:0]      idx
);

  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic          busy_r;
  logic [AW-1:0] idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (busy_r) begin
      if (idx_r == LAST) begin
        busy_r <= 1'b0;
      end else begin
        idx_r <= idx_r + AW'(1);
      end
    end
  end

  assign busy = busy_r;
  assign idx  = idx_r;

endmodule
`default_nettype wire

>>> tb/tb_signed_latency_histogram.sv
`timescale 1ns / 1ps
module tb_signed_latency_histogram;
  import slh_pkg::*;

  localparam int NBINS          = BIN_COUNT_DEF;
  localparam int WATCHDOG_LIMIT = 20000;  // covers a full clear sweep many times over
  localparam int RANDOM_BLOCKS  = 13;
  localparam int BLOCK_ITEMS    = 150;

  typedef struct {
    logic [OUT_CNT_W-1:0] count;
    logic [STAT_W-1:0]    status;
  } bin_result_t;

  // Tracks both bin banks and the two bounds, and holds the results still owed
  // by the block in the order the requests were accepted.
  class bin_count_tracker;
    bit [OUT_CNT_W-1:0] pos_bins [NBINS];
    bit [OUT_CNT_W-1:0] neg_bins [NBINS];
    bit [BOUND_W-1:0]   max_pos;
    bit [BOUND_W-1:0]   max_neg;
    bin_result_t        expected_counts [$];
    int                 mismatches;

    function new();
      clear_all();
      max_pos    = MAX_POS_RST;
      max_neg    = MAX_NEG_RST;
      mismatches = 0;
    endfunction

    function void clear_all();
      foreach (pos_bins[i]) begin
        pos_bins[i] = '0;
        neg_bins[i] = '0;
      end
    endfunction

    function void set_bound(logic [CFG_IDX_W-1:0] idx, logic [BOUND_W-1:0] val);
      if (idx == CFG_MAX_POS) max_pos = val;
      else if (idx == CFG_MAX_NEG) max_neg = val;
    endfunction

    // Negative bin zero is never used; -1024 has no bin at any bound.
    function bit in_bounds(logic signed [VAL_W-1:0] v, output bit neg, output int mag);
      neg = v[VAL_W-1];
      mag = neg ? -int'(v) : int'(v);
      if (neg) return (mag >= 1) && (mag <= max_neg) && (mag < NBINS);
      return (mag <= max_pos) && (mag < NBINS);
    endfunction

    function void note_request(logic [REQ_W-1:0] req, logic signed [VAL_W-1:0] sample,
                               logic signed [VAL_W-1:0] index);
      bin_result_t        r;
      bit                 neg;
      int                 mag;
      bit [OUT_CNT_W-1:0] cnt;
      r.count  = '0;
      r.status = ST_OK;
      case (req)
        REQ_COUNT: begin
          if (!in_bounds(sample, neg, mag)) begin
            r.status = ST_RANGE;
          end else begin
            cnt = neg ? neg_bins[mag] : pos_bins[mag];
            // a full bin keeps its count and flags it
            if (cnt == '1) begin
              r.status = ST_SAT;
            end else begin
              cnt = cnt + 1'b1;
            end
            r.count = cnt;
            if (neg) neg_bins[mag] = cnt;
            else pos_bins[mag] = cnt;
          end
        end
        REQ_READ: begin
          if (!in_bounds(index, neg, mag)) r.status = ST_RANGE;
          else r.count = neg ? neg_bins[mag] : pos_bins[mag];
        end
        REQ_CLEAR: clear_all();
        default: ;
      endcase
      expected_counts.push_back(r);
    endfunction

    function void check_result(logic [OUT_CNT_W-1:0] count, logic [STAT_W-1:0] status);
      bin_result_t e;
      if (expected_counts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result with nothing outstanding: count %0d status %0d", count, status);
        return;
      end
      e = expected_counts.pop_front();
      if (count !== e.count || status !== e.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("bin result mismatch: expected count %0d status %0d, got count %0d status %0d",
                   e.count, e.status, count, status);
      end
    endfunction
  endclass

  logic                        clk;
  logic                        rst_n;
  logic                        cfg_we;
  logic [CFG_IDX_W-1:0]        cfg_index;
  logic [BOUND_W-1:0]          cfg_wdata;
  logic                        in_valid;
  logic                        in_stall;
  logic [REQ_W-1:0]            in_req_type;
  logic signed [VAL_W-1:0]     in_sample_value;
  logic signed [VAL_W-1:0]     in_bin_index;
  logic                        out_valid;
  logic                        out_stall;
  logic [OUT_CNT_W-1:0]        out_bin_count;
  logic [STAT_W-1:0]           out_status;

  bin_count_tracker tracker = new();

  // idle percentages of the current phase, for the sender and the receiver
  int send_idle_pct;
  int stall_pct;
  int idle_cycles;

  signed_latency_histogram dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_sample_value (in_sample_value),
    .in_bin_index    (in_bin_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_bin_count   (out_bin_count),
    .out_status      (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver: stall decided each falling edge from the phase setting.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Monitor: every handshake is seen here, at the rising edge that completes it.
  // Config writes go to the tracker at the same edge the block takes them.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) tracker.set_bound(cfg_index, cfg_wdata);
      if (in_valid && !in_stall)
        tracker.note_request(in_req_type, in_sample_value, in_bin_index);
      if (out_valid && !out_stall) tracker.check_result(out_bin_count, out_status);
    end
  end

  // Watchdog: counts cycles with no item moving on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Present one item after a random gap and hold it until taken. Valid is only
  // ever assigned once per falling edge: the next call either lowers it for a
  // gap or puts the next item straight on the bus.
  task automatic send_item(input logic [REQ_W-1:0] req, input logic signed [VAL_W-1:0] sv,
                           input logic signed [VAL_W-1:0] bi);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_req_type     <= req;
    in_sample_value <= sv;
    in_bin_index    <= bi;
    do @(posedge clk); while (in_stall);
  endtask

  // Wait until every owed result is back, then a few cycles more so the
  // pipeline is empty before the bounds change.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.expected_counts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_bounds(input logic [BOUND_W-1:0] pos, input logic [BOUND_W-1:0] neg);
    drain_results();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MAX_POS;
    cfg_wdata <= pos;
    @(negedge clk);
    cfg_index <= CFG_MAX_NEG;
    cfg_wdata <= neg;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_idling(input int phase);
    case (phase)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 73; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 73; end
      default: begin send_idle_pct = 17; stall_pct = 17; end
    endcase
  endtask

  // Values: a cluster of hot bins around zero so counts pile up and reads hit
  // fresh writes, values inside the current bounds, and raw 11-bit noise.
  task automatic random_value(output logic signed [VAL_W-1:0] v);
    int pick;
    int t;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      t = int'($urandom_range(0, 8)) - 4;
    end else if (pick < 8) begin
      if (tracker.max_neg > 0 && $urandom_range(0, 1) == 1)
        t = -int'($urandom_range(1, tracker.max_neg));
      else
        t = int'($urandom_range(0, tracker.max_pos));
    end else begin
      t = $urandom;
    end
    v = t[VAL_W-1:0];
  endtask

  task automatic random_item();
    logic [REQ_W-1:0]        req;
    logic signed [VAL_W-1:0] sv;
    logic signed [VAL_W-1:0] bi;
    int                      r;
    r = $urandom_range(0, 99);
    random_value(sv);
    random_value(bi);
    // clears are kept rare: each one costs a full sweep of the banks
    if (r < 60) req = REQ_COUNT;
    else if (r < 94) req = REQ_READ;
    else if (r < 96) req = REQ_CLEAR;
    else req = REQ_NOP;
    send_item(req, sv, bi);
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_MAX_POS;
    cfg_wdata       = '0;
    in_valid        = 1'b0;
    in_req_type     = REQ_NOP;
    in_sample_value = '0;
    in_bin_index    = '0;
    out_stall       = 1'b0;
    idle_cycles     = 0;
    set_idling(0);
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: both banks fully open. Back-to-back counts of one bin exercise
    // the write forwarding; -1024 has no bin. Saturation needs 2^32 counts of
    // one bin, so it is only covered by the predictor, not reached here.
    write_bounds(10'd1023, 10'd1023);
    send_item(REQ_COUNT, 11'sd0, 11'sd0);
    send_item(REQ_COUNT, 11'sd0, -11'sd1);
    send_item(REQ_COUNT, 11'sd1023, 11'sd0);
    send_item(REQ_COUNT, -11'sd1, 11'sd0);
    send_item(REQ_COUNT, -11'sd1023, 11'sd0);
    send_item(REQ_COUNT, 11'sh400, 11'sd0);
    send_item(REQ_READ, 11'sd5, 11'sd0);
    send_item(REQ_READ, 11'sd0, 11'sd1023);
    send_item(REQ_READ, 11'sd0, -11'sd1);
    send_item(REQ_READ, 11'sd0, -11'sd1023);
    send_item(REQ_READ, 11'sd0, 11'sh400);
    send_item(REQ_READ, 11'sd0, 11'sd5);
    send_item(REQ_NOP, 11'sd1023, 11'sh400);
    send_item(REQ_CLEAR, -11'sd1, 11'sd1023);
    send_item(REQ_READ, 11'sd0, 11'sd0);
    send_item(REQ_COUNT, 11'sd0, 11'sd0);
    send_item(REQ_READ, 11'sd0, 11'sd0);

    // Tightest bounds: only positive bin zero exists.
    write_bounds(10'd0, 10'd0);
    send_item(REQ_COUNT, 11'sd0, 11'sd0);
    send_item(REQ_COUNT, 11'sd1, 11'sd0);
    send_item(REQ_COUNT, -11'sd1, 11'sd0);
    send_item(REQ_READ, 11'sd0, 11'sd0);
    send_item(REQ_READ, 11'sd0, -11'sd1);
    send_item(REQ_READ, 11'sd0, 11'sd1);

    // Random blocks, each with its own bounds and idling phase.
    for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      case (blk % 6)
        0: write_bounds(10'd1023, 10'd1023);
        1: write_bounds(10'd0, 10'd1023);
        2: write_bounds(10'd1023, 10'd0);
        4: write_bounds(BOUND_W'($urandom_range(0, 15)), BOUND_W'($urandom_range(0, 15)));
        default: write_bounds(BOUND_W'($urandom), BOUND_W'($urandom));
      endcase
      set_idling(blk % 4);
      for (int i = 0; i < BLOCK_ITEMS; i++) random_item();
    end

    set_idling(0);
    drain_results();
    repeat (10) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.expected_counts.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/slh_pkg.sv
hw/rtl/slh_bank.sv
hw/rtl/slh_clear.sv
hw/rtl/signed_latency_histogram.sv
tb/tb_signed_latency_histogram.sv
